@@ design/csvt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the CSV field tokenizer.
// Used by csvt_front, csvt_fifo, csvt_back and csv_field_tokenizer_top.
package csvt_pkg;

  localparam int LINE_BITS  = 32;
  localparam int FIELD_BITS = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] BOM_B0      = 8'hEF;
  localparam logic [7:0] BOM_B1      = 8'hBB;
  localparam logic [7:0] BOM_B2      = 8'hBF;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    OK_BYTE      = 3'd0,
    OK_FIELD_END = 3'd1,
    OK_ROW_END   = 3'd2,
    OK_QUOTE_ERR = 3'd3,
    OK_DOC_END   = 3'd4
  } out_kind_t;

  // One classified operation passed from the front to the back.
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
    logic       is_quote;
    logic       is_delim;
    logic       is_cr;
    logic       is_lf;
    logic [1:0] replay_n;
    logic [1:0] replay_delim;
    logic       main_emits;
  } tok_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

@@ design/csvt_front.sv @@
`timescale 1ns / 1ps
// Front end: input handshake, delimiter register, byte-order mark stripping
// and byte classification. Depends on csvt_pkg.
module csvt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [7:0]            in_byte,
  input  csvt_pkg::fifo_status_t q_status,
  output logic                  push,
  output csvt_pkg::tok_op_t     push_op
);

  logic [7:0] delim_r;
  logic       at_doc_r;
  logic       at_doc_nxt;
  logic [1:0] seen_r;
  logic [1:0] seen_nxt;
  logic       accept;
  logic       mark_hit;
  logic [7:0] bom_exp;
  logic       fs_after;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (seen_r)
      2'd0:    bom_exp = csvt_pkg::BOM_B0;
      2'd1:    bom_exp = csvt_pkg::BOM_B1;
      default: bom_exp = csvt_pkg::BOM_B2;
    endcase
  end

  assign mark_hit = (in_kind == csvt_pkg::KIND_BYTE) && at_doc_r && (in_byte == bom_exp);
  assign push     = accept && !mark_hit;

  // field_started after replaying the partial mark from a clean document
  assign fs_after = (seen_r == 2'd1) ? (delim_r != csvt_pkg::BOM_B0)
                                     : (delim_r != csvt_pkg::BOM_B1);

  always_comb begin
    push_op.is_end          = (in_kind == csvt_pkg::KIND_END);
    push_op.data            = in_byte;
    push_op.is_quote        = (in_byte == csvt_pkg::CH_QUOTE);
    push_op.is_delim        = (in_byte == delim_r);
    push_op.is_cr           = (in_byte == csvt_pkg::CH_CR);
    push_op.is_lf           = (in_byte == csvt_pkg::CH_LF);
    push_op.replay_n        = at_doc_r ? seen_r : 2'd0;
    push_op.replay_delim[0] = (delim_r == csvt_pkg::BOM_B0);
    push_op.replay_delim[1] = (delim_r == csvt_pkg::BOM_B1);
    push_op.main_emits      = !((in_byte == csvt_pkg::CH_QUOTE) && !fs_after);
  end

  always_comb begin
    at_doc_nxt = at_doc_r;
    seen_nxt   = seen_r;
    if (accept) begin
      if (in_kind == csvt_pkg::KIND_END) begin
        at_doc_nxt = 1'b1;
        seen_nxt   = 2'd0;
      end else if (mark_hit && (seen_r != 2'd2)) begin
        seen_nxt = seen_r + 2'd1;
      end else begin
        at_doc_nxt = 1'b0;
        seen_nxt   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r  <= csvt_pkg::DELIM_RESET;
      at_doc_r <= 1'b1;
      seen_r   <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        delim_r <= cfg_wr_data;
      end
      at_doc_r <= at_doc_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

@@ design/csvt_fifo.sv @@
`timescale 1ns / 1ps
// Short operation queue between the front and the back of the tokenizer.
// Depends on csvt_pkg.
module csvt_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  csvt_pkg::tok_op_t      push_op,
  input  logic                   pop,
  output csvt_pkg::fifo_status_t status,
  output csvt_pkg::tok_op_t      head
);

  localparam logic [csvt_pkg::FIFO_AW:0] FULL_CNT =
    (csvt_pkg::FIFO_AW + 1)'(csvt_pkg::FIFO_DEPTH);
  localparam logic [csvt_pkg::FIFO_AW-1:0] LAST_PTR =
    csvt_pkg::FIFO_AW'(csvt_pkg::FIFO_DEPTH - 1);

  csvt_pkg::tok_op_t             mem_r [csvt_pkg::FIFO_DEPTH];
  logic [csvt_pkg::FIFO_AW-1:0] wr_ptr_r;
  logic [csvt_pkg::FIFO_AW-1:0] rd_ptr_r;
  logic [csvt_pkg::FIFO_AW:0]   count_r;
  logic                          do_push;
  logic                          do_pop;

  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ design/csvt_back.sv @@
`timescale 1ns / 1ps
// Back end: quoting state, line and field counters, at most one result per
// step into the output register. Depends on csvt_pkg.
module csvt_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  csvt_pkg::fifo_status_t         q_status,
  input  csvt_pkg::tok_op_t              head,
  output logic                           pop,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [2:0]                     out_kind,
  output logic [7:0]                     out_byte,
  output logic [csvt_pkg::LINE_BITS-1:0] out_line_number,
  output logic [csvt_pkg::FIELD_BITS-1:0] out_field_number,
  output logic                           out_last
);

  logic                            in_quotes_r, in_quotes_nxt;
  logic                            fs_r, fs_nxt;
  logic                            qp_r, qp_nxt;
  logic                            qcr_r, qcr_nxt;
  logic                            skip_r, skip_nxt;
  logic [csvt_pkg::LINE_BITS-1:0]  line_r, line_nxt, line_up;
  logic [csvt_pkg::FIELD_BITS-1:0] fields_r, fields_nxt, fields_up;
  logic [1:0]                      rp_idx_r, rp_idx_nxt;
  logic                            end_mid_r, end_mid_nxt;

  logic                            out_valid_r;
  csvt_pkg::out_kind_t             out_kind_r;
  logic [7:0]                      out_byte_r;
  logic [csvt_pkg::LINE_BITS-1:0]  out_line_r;
  logic [csvt_pkg::FIELD_BITS-1:0] out_field_r;
  logic                            out_last_r;

  logic                            out_free;
  logic                            step;
  logic                            replaying;
  logic                            do_byte;
  logic                            byte_last;
  logic                            go_out;
  logic                            done;
  logic                            emit;
  csvt_pkg::out_kind_t             e_kind;
  logic [7:0]                      e_byte;
  logic [csvt_pkg::LINE_BITS-1:0]  e_line;
  logic [csvt_pkg::FIELD_BITS-1:0] e_field;
  logic                            e_last;
  logic [7:0]                      c_data;
  logic                            c_q, c_d, c_cr, c_lf;

  assign out_free  = !out_valid_r || out_ready;
  assign step      = !q_status.empty && out_free;
  assign pop       = step && done;
  assign replaying = (rp_idx_r < head.replay_n);
  assign line_up   = (&line_r) ? line_r : line_r + 1'b1;
  assign fields_up = (&fields_r) ? fields_r : fields_r + 1'b1;

  always_comb begin
    if (replaying) begin
      c_data = (rp_idx_r == 2'd0) ? csvt_pkg::BOM_B0 : csvt_pkg::BOM_B1;
      c_q    = 1'b0;
      c_d    = head.replay_delim[rp_idx_r[0]];
      c_cr   = 1'b0;
      c_lf   = 1'b0;
    end else begin
      c_data = head.data;
      c_q    = head.is_quote;
      c_d    = head.is_delim;
      c_cr   = head.is_cr;
      c_lf   = head.is_lf;
    end
  end

  always_comb begin
    in_quotes_nxt = in_quotes_r;
    fs_nxt        = fs_r;
    qp_nxt        = qp_r;
    qcr_nxt       = qcr_r;
    skip_nxt      = skip_r;
    line_nxt      = line_r;
    fields_nxt    = fields_r;
    rp_idx_nxt    = rp_idx_r;
    end_mid_nxt   = end_mid_r;
    done          = 1'b0;
    do_byte       = 1'b0;
    byte_last     = 1'b0;
    go_out        = 1'b0;
    emit          = 1'b0;
    e_kind        = csvt_pkg::OK_BYTE;
    e_byte        = 8'd0;
    e_line        = line_r;
    e_field       = fields_r;
    e_last        = 1'b0;

    if (replaying) begin
      do_byte    = 1'b1;
      byte_last  = ((rp_idx_r + 2'd1) == head.replay_n) && !head.is_end && !head.main_emits;
      rp_idx_nxt = rp_idx_r + 2'd1;
    end else if (!head.is_end) begin
      if (qcr_r && !head.is_lf) begin
        // release the held CR, the byte itself follows next step
        emit     = 1'b1;
        e_byte   = csvt_pkg::CH_CR;
        e_last   = head.is_quote || head.is_cr;
        line_nxt = line_up;
        qcr_nxt  = 1'b0;
      end else begin
        do_byte   = 1'b1;
        byte_last = 1'b1;
        done      = 1'b1;
      end
    end else begin
      if (qcr_r) begin
        emit     = 1'b1;
        e_byte   = csvt_pkg::CH_CR;
        line_nxt = line_up;
        qcr_nxt  = 1'b0;
      end else if (!end_mid_r && ((in_quotes_r && !qp_r) || fs_r || (fields_r != '0))) begin
        emit        = 1'b1;
        end_mid_nxt = 1'b1;
        if (in_quotes_r && !qp_r) begin
          e_kind = csvt_pkg::OK_QUOTE_ERR;
        end else begin
          e_kind     = csvt_pkg::OK_ROW_END;
          e_field    = fields_up;
          fields_nxt = '0;
          fs_nxt     = 1'b0;
          line_nxt   = line_up;
        end
      end else begin
        emit          = 1'b1;
        e_kind        = csvt_pkg::OK_DOC_END;
        e_last        = 1'b1;
        done          = 1'b1;
        in_quotes_nxt = 1'b0;
        fs_nxt        = 1'b0;
        qp_nxt        = 1'b0;
        skip_nxt      = 1'b0;
        line_nxt      = csvt_pkg::LINE_BITS'(1);
        fields_nxt    = '0;
      end
    end

    if (do_byte) begin
      skip_nxt = 1'b0;
      e_last   = byte_last;
      if (skip_r && c_lf) begin
        emit = 1'b0;
      end else if (qp_r) begin
        qp_nxt = 1'b0;
        if (c_q) begin
          emit   = 1'b1;
          e_byte = csvt_pkg::CH_QUOTE;
        end else begin
          in_quotes_nxt = 1'b0;
          go_out        = 1'b1;
        end
      end else if (qcr_r) begin
        emit     = 1'b1;
        e_byte   = csvt_pkg::CH_LF;
        line_nxt = line_up;
        qcr_nxt  = 1'b0;
      end else if (in_quotes_r) begin
        if (c_q) begin
          qp_nxt = 1'b1;
        end else if (c_cr) begin
          qcr_nxt = 1'b1;
        end else begin
          emit   = 1'b1;
          e_byte = c_data;
          if (c_lf) begin
            line_nxt = line_up;
          end
        end
      end else begin
        go_out = 1'b1;
      end

      if (go_out) begin
        if (c_q && !fs_r) begin
          in_quotes_nxt = 1'b1;
          fs_nxt        = 1'b1;
        end else if (c_d) begin
          emit       = 1'b1;
          e_kind     = csvt_pkg::OK_FIELD_END;
          e_field    = fields_up;
          fields_nxt = fields_up;
          fs_nxt     = 1'b0;
        end else if (c_cr || c_lf) begin
          emit       = 1'b1;
          e_kind     = csvt_pkg::OK_ROW_END;
          e_field    = fields_up;
          fields_nxt = '0;
          fs_nxt     = 1'b0;
          line_nxt   = line_up;
          skip_nxt   = c_cr;
        end else begin
          emit   = 1'b1;
          e_byte = c_data;
          fs_nxt = 1'b1;
        end
      end
    end

    if (done) begin
      rp_idx_nxt  = 2'd0;
      end_mid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      fs_r        <= 1'b0;
      qp_r        <= 1'b0;
      qcr_r       <= 1'b0;
      skip_r      <= 1'b0;
      line_r      <= csvt_pkg::LINE_BITS'(1);
      fields_r    <= '0;
      rp_idx_r    <= 2'd0;
      end_mid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        in_quotes_r <= in_quotes_nxt;
        fs_r        <= fs_nxt;
        qp_r        <= qp_nxt;
        qcr_r       <= qcr_nxt;
        skip_r      <= skip_nxt;
        line_r      <= line_nxt;
        fields_r    <= fields_nxt;
        rp_idx_r    <= rp_idx_nxt;
        end_mid_r   <= end_mid_nxt;
      end
      if (out_free) begin
        out_valid_r <= step && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_kind_r  <= e_kind;
      out_byte_r  <= e_byte;
      out_line_r  <= e_line;
      out_field_r <= e_field;
      out_last_r  <= e_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_byte         = out_byte_r;
  assign out_line_number  = out_line_r;
  assign out_field_number = out_field_r;
  assign out_last         = out_last_r;

  a_pending_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(qp_r && qcr_r))
    else $error("quote and CR pending at once");

  a_quote_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    qp_r |-> in_quotes_r)
    else $error("quote pending outside a quoted field");

  a_skip_outside_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> (!in_quotes_r && !fs_r))
    else $error("LF skip armed inside a field");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter reached zero");

  a_doc_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && emit && (e_kind == csvt_pkg::OK_DOC_END)) |=>
      ((line_r == csvt_pkg::LINE_BITS'(1)) && (fields_r == '0) && !in_quotes_r))
    else $error("document end left state behind");

endmodule

@@ design/csv_field_tokenizer_top.sv @@
`timescale 1ns / 1ps
// CSV field tokenizer, top level: wires the front end, the operation queue
// and the back end. Depends on csvt_pkg, csvt_front, csvt_fifo, csvt_back.
//
// Accepts one document byte or end-of-input mark per cycle while the queue
// is not full; a byte of a leading byte-order mark is dropped in the front
// end. The back end delivers at most one result per step and sets the rate:
// ordinary bytes and field or row ends run at one item per cycle while
// out_ready does not hold the output, a byte other than LF after a CR held
// in quotes first releases the CR, an end-of-input mark may release a held
// CR and end a row or flag a quote error before the document end, and
// each byte of a partial byte-order mark is replayed as its own step. A
// four-entry queue separates the two ends, so input is taken while results
// wait on out_ready until it fills. The delimiter resets to comma; the user
// must write it only while the block is idle; the block does not enforce it.
module csv_field_tokenizer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [7:0]                     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_kind,
  output logic [7:0]                     out_byte,
  output logic [csvt_pkg::LINE_BITS-1:0] out_line_number,
  output logic [csvt_pkg::FIELD_BITS-1:0] out_field_number,
  output logic                           out_last
);

  csvt_pkg::fifo_status_t q_status;
  csvt_pkg::tok_op_t      push_op;
  csvt_pkg::tok_op_t      head;
  logic                   push;
  logic                   pop;

  csvt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_byte     (in_byte),
    .q_status    (q_status),
    .push        (push),
    .push_op     (push_op)
  );

  csvt_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .status  (q_status),
    .head    (head)
  );

  csvt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .head             (head),
    .pop              (pop),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_line_number  (out_line_number),
    .out_field_number (out_field_number),
    .out_last         (out_last)
  );

endmodule
